FILE: sv/pads_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, widths and types of the particle attract/drag step core.
// No dependencies; pads_front, pads_div, pads_integ and the top level import this package.

package pads_pkg;

	// Default number of fraction bits of positions and velocities
	localparam int FRAC_BITS_DEF = 16;

	// Field widths
	localparam int POS_W  = 32;
	localparam int ATT_W  = 16;
	localparam int DT_W   = 16;
	localparam int DRAG_W = 16;
	localparam int STR_W  = 24;
	localparam int MIN_W  = 20;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRAG     = 2'd0,
		REG_STRENGTH = 2'd1,
		REG_MIN_DSQ  = 2'd2
	} cfg_reg_t;

	localparam logic [DRAG_W-1:0] DRAG_RST     = 16'd1024;
	localparam logic [STR_W-1:0]  STRENGTH_RST = 24'd750000;
	localparam logic [MIN_W-1:0]  MIN_DSQ_RST  = 20'd900;

	// Distance path: Q.8 deltas, Q.16 squared distance
	localparam int DQ_MAG_W = 31;
	localparam logic [DQ_MAG_W-1:0] DQ_MAG_MAX = {DQ_MAG_W{1'b1}};
	localparam int SQ_W     = 2 * DQ_MAG_W;
	localparam int DSQ_W    = SQ_W + 1;
	localparam int DSQ_FRAC = 16;
	localparam int NUM_W    = STR_W + DQ_MAG_W;

	// Attraction quotient, capped at 2^40
	localparam int QUO_W = 41;
	localparam logic [QUO_W-1:0] ATTR_CAP = {1'b1, {(QUO_W-1){1'b0}}};

	// Pipeline depths
	localparam int DIV_STEP  = 2;
	localparam int DIV_LAT   = (QUO_W + DIV_STEP - 1) / DIV_STEP;
	localparam int FRONT_LAT = 4;
	localparam int INTEG_LAT = 5;

	// Flags leaving the distance front end
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic attracted;
	} front_flags_t;

	// Particle fields carried alongside the distance path and the divider
	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] vel_x;
		logic [POS_W-1:0] vel_y;
		logic [DT_W-1:0]  time_step;
		logic             last;
	} side_t;

	// Flags carried alongside the integrator
	typedef struct packed {
		logic attracted;
		logic last;
	} out_flags_t;

endpackage
`default_nettype wire

FILE: sv/pads_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// Enabled shift line that keeps side data in step with the pipeline.
// No dependencies.

module pads_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] din,
	output logic      [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	// advance every tap together with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule
`default_nettype wire

FILE: sv/pads_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Distance front end: deltas to the attractor, squared distance, attraction test.
// Depends on pads_pkg.

module pads_front import pads_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [ATT_W-1:0] attractor_x,
	input  wire logic signed [ATT_W-1:0] attractor_y,
	input  wire logic                    attract_on,
	input  wire logic [STR_W-1:0]        strength,
	input  wire logic [MIN_W-1:0]        min_dsq,
	output logic      [NUM_W-1:0]        num_x,
	output logic      [NUM_W-1:0]        num_y,
	output logic      [DSQ_W-1:0]        dsq,
	output front_flags_t                 flags
);

	localparam int ATT_SH_W = ATT_W + FRAC_BITS;
	localparam int DX_W     = ((ATT_SH_W > POS_W) ? ATT_SH_W : POS_W) + 1;
	localparam int SHR      = FRAC_BITS - 8;
	localparam int DQ_W     = DX_W - SHR;

	// magnitude of a Q.8 delta, saturated to 2^31-1
	function automatic logic [DQ_MAG_W-1:0] sat_mag(input logic signed [DQ_W-1:0] dq);
		logic signed [DQ_W:0] w;
		logic [DQ_W:0]        m;
		begin
			w = dq;
			m = (w < 0) ? -w : w;
			if (64'(m) > 64'(DQ_MAG_MAX)) begin
				sat_mag = DQ_MAG_MAX;
			end else begin
				sat_mag = DQ_MAG_W'(m);
			end
		end
	endfunction

	logic signed [ATT_SH_W-1:0] att_x_sh, att_y_sh;
	logic signed [DX_W-1:0]     dx, dy;

	logic signed [DQ_W-1:0]  dqx_s1, dqy_s1;
	logic                    on_s1;
	logic [DQ_MAG_W-1:0]     magx_s2, magy_s2;
	logic                    negx_s2, negy_s2, on_s2;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3;
	logic [NUM_W-1:0]        numx_s3, numy_s3;
	logic                    negx_s3, negy_s3, on_s3;
	logic [DSQ_W-1:0]        dsq_c;
	logic [DSQ_W-1:0]        dsq_s4;
	logic [NUM_W-1:0]        numx_s4, numy_s4;
	front_flags_t            flags_s4;

	// deltas in Q.F, then floor to Q.8
	always_comb begin
		att_x_sh = {attractor_x, {FRAC_BITS{1'b0}}};
		att_y_sh = {attractor_y, {FRAC_BITS{1'b0}}};
		dx = att_x_sh - pos_x;
		dy = att_y_sh - pos_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dqx_s1 <= DQ_W'(dx >>> SHR);
			dqy_s1 <= DQ_W'(dy >>> SHR);
			on_s1  <= attract_on;
		end
	end

	// saturate and split into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			magx_s2 <= sat_mag(dqx_s1);
			magy_s2 <= sat_mag(dqy_s1);
			negx_s2 <= dqx_s1[DQ_W-1];
			negy_s2 <= dqy_s1[DQ_W-1];
			on_s2   <= on_s1;
		end
	end

	// squares and strength products
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3  <= SQ_W'(magx_s2) * SQ_W'(magx_s2);
			sqy_s3  <= SQ_W'(magy_s2) * SQ_W'(magy_s2);
			numx_s3 <= NUM_W'(strength) * NUM_W'(magx_s2);
			numy_s3 <= NUM_W'(strength) * NUM_W'(magy_s2);
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			on_s3   <= on_s2;
		end
	end

	// squared distance and the threshold test (strictly greater)
	assign dsq_c = DSQ_W'(sqx_s3) + DSQ_W'(sqy_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			dsq_s4             <= dsq_c;
			numx_s4            <= numx_s3;
			numy_s4            <= numy_s3;
			flags_s4.neg_x     <= negx_s3;
			flags_s4.neg_y     <= negy_s3;
			flags_s4.attracted <= on_s3 && (dsq_c > DSQ_W'({min_dsq, {DSQ_FRAC{1'b0}}}));
		end
	end

	assign num_x = numx_s4;
	assign num_y = numy_s4;
	assign dsq   = dsq_s4;
	assign flags = flags_s4;

endmodule
`default_nettype wire

FILE: sv/pads_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: trunc(num * 2^SHIFT / den), capped at 2^40.
// Depends on pads_pkg; DIV_STEP quotient bits are settled per stage.

module pads_div import pads_pkg::*; #(
	parameter int SHIFT = 8 + FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DSQ_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	localparam int NSH_W = NUM_W + SHIFT;
	localparam int HI_W  = NSH_W - QUO_W;
	localparam int NST   = DIV_LAT;

	logic [NSH_W-1:0] nsh;
	logic [HI_W-1:0]  hi;

	logic [DSQ_W-1:0] rem_s [NST];
	logic [DSQ_W-1:0] den_s [NST];
	logic [QUO_W-1:0] quo_s [NST];
	logic [QUO_W-1:0] lo_s  [NST];
	logic [NST-1:0]   ovf_s;

	// high part seeds the remainder; it must sit below den or the quotient overflows
	assign nsh = {num, {SHIFT{1'b0}}};
	assign hi  = nsh[NSH_W-1:QUO_W];

	for (genvar j = 0; j < NST; j++) begin : g_stage
		logic [DSQ_W-1:0] rem_in, den_in, rem_nx;
		logic [QUO_W-1:0] quo_in, lo_in, quo_nx, lo_nx;
		logic             ovf_in;
		logic [DSQ_W:0]   t;

		if (j == 0) begin : g_first
			assign rem_in = DSQ_W'(hi);
			assign den_in = den;
			assign quo_in = '0;
			assign lo_in  = nsh[QUO_W-1:0];
			assign ovf_in = (DSQ_W'(hi) >= den);
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
			assign lo_in  = lo_s[j-1];
			assign ovf_in = ovf_s[j-1];
		end

		// shift in the next numerator bits, subtract where it fits
		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			lo_nx  = lo_in;
			t      = '0;
			for (int i = 0; i < DIV_STEP; i++) begin
				if (j * DIV_STEP + i < QUO_W) begin
					t     = {rem_nx, lo_nx[QUO_W-1]};
					lo_nx = {lo_nx[QUO_W-2:0], 1'b0};
					if (t >= {1'b0, den_in}) begin
						t      = t - {1'b0, den_in};
						quo_nx = {quo_nx[QUO_W-2:0], 1'b1};
					end else begin
						quo_nx = {quo_nx[QUO_W-2:0], 1'b0};
					end
					rem_nx = t[DSQ_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= rem_nx;
				den_s[j] <= den_in;
				quo_s[j] <= quo_nx;
				lo_s[j]  <= lo_nx;
				ovf_s[j] <= ovf_in;
			end
		end
	end

	// clamp to the attraction cap
	assign quo = (ovf_s[NST-1] || (quo_s[NST-1] > ATTR_CAP)) ? ATTR_CAP : quo_s[NST-1];

endmodule
`default_nettype wire

FILE: sv/pads_integ.sv
`timescale 1ns / 1ps
`default_nettype none
// One axis of the integration step: drag, acceleration, new position and velocity.
// Depends on pads_pkg.

module pads_integ import pads_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [POS_W-1:0] pos,
	input  wire logic signed [POS_W-1:0] vel,
	input  wire logic [DT_W-1:0]         dt,
	input  wire logic [DRAG_W-1:0]       drag,
	input  wire logic [QUO_W-1:0]        quo,
	input  wire logic                    neg,
	input  wire logic                    attracted,
	output logic signed [POS_W-1:0]      new_pos,
	output logic signed [POS_W-1:0]      new_vel
);

	localparam int ATTR_W = QUO_W + 1;
	localparam int VD_W   = POS_W + DRAG_W + 1;
	localparam int VDT_W  = POS_W + DT_W + 1;
	localparam int DRG_W  = VD_W - 8;
	localparam int ACC_W  = ATTR_W;
	localparam int ADT_W  = ACC_W + DT_W + 1;
	localparam int AT_W   = ADT_W - DT_W;
	localparam int ATDT_W = AT_W + DT_W + 1;
	localparam int VH_W   = ADT_W - (DT_W + 1);
	localparam int PH_W   = ATDT_W - (DT_W + 1);
	localparam int SUM_W  = PH_W + 3;

	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

	function automatic logic [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		begin
			if (x > SAT_HI) begin
				sat32 = SAT_HI[POS_W-1:0];
			end else if (x < SAT_LO) begin
				sat32 = SAT_LO[POS_W-1:0];
			end else begin
				sat32 = x[POS_W-1:0];
			end
		end
	endfunction

	logic signed [DT_W:0]     dt_sv, dt_sv2, dt_sv3;
	logic signed [DRAG_W:0]   drag_sv;
	logic signed [ATTR_W-1:0] attr_c;
	logic signed [VD_W-1:0]   vd_c;
	logic signed [VDT_W-1:0]  vdt_c;
	logic signed [AT_W-1:0]   at_c;
	logic signed [SUM_W-1:0]  psum, vsum;

	logic signed [ATTR_W-1:0] attr_s1;
	logic signed [DRG_W-1:0]  drg_s1;
	logic signed [POS_W-1:0]  vdt_s1, vdt_s2, vdt_s3, vdt_s4;
	logic signed [POS_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s4;
	logic signed [POS_W-1:0]  vel_s1, vel_s2, vel_s3, vel_s4;
	logic [DT_W-1:0]          dt_s1, dt_s2, dt_s3;
	logic signed [ACC_W-1:0]  a_s2;
	logic signed [ADT_W-1:0]  adt_s3;
	logic signed [ATDT_W-1:0] atdt_s4;
	logic signed [VH_W-1:0]   vh_s4;
	logic [POS_W-1:0]         npos_s5, nvel_s5;

	// signed attraction, drag and drift products
	always_comb begin
		dt_sv   = {1'b0, dt};
		drag_sv = {1'b0, drag};
		if (!attracted) begin
			attr_c = '0;
		end else if (neg) begin
			attr_c = -ATTR_W'(quo);
		end else begin
			attr_c = ATTR_W'(quo);
		end
		vd_c  = vel * drag_sv;
		vdt_c = vel * dt_sv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			attr_s1 <= attr_c;
			drg_s1  <= DRG_W'(vd_c >>> 8);
			vdt_s1  <= POS_W'(vdt_c >>> DT_W);
			pos_s1  <= pos;
			vel_s1  <= vel;
			dt_s1   <= dt;
		end
	end

	// acceleration
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= attr_s1 - drg_s1;
			vdt_s2 <= vdt_s1;
			pos_s2 <= pos_s1;
			vel_s2 <= vel_s1;
			dt_s2  <= dt_s1;
		end
	end

	// a * dt
	assign dt_sv2 = {1'b0, dt_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			adt_s3 <= a_s2 * dt_sv2;
			vdt_s3 <= vdt_s2;
			pos_s3 <= pos_s2;
			vel_s3 <= vel_s2;
			dt_s3  <= dt_s2;
		end
	end

	// (a * dt) * dt and the half step of velocity
	assign dt_sv3 = {1'b0, dt_s3};
	assign at_c   = AT_W'(adt_s3 >>> DT_W);

	always_ff @(posedge clk) begin
		if (en) begin
			atdt_s4 <= at_c * dt_sv3;
			vh_s4   <= VH_W'(adt_s3 >>> (DT_W + 1));
			vdt_s4  <= vdt_s3;
			pos_s4  <= pos_s3;
			vel_s4  <= vel_s3;
		end
	end

	// sums and saturation
	always_comb begin
		psum = SUM_W'(pos_s4) + SUM_W'(vdt_s4) + SUM_W'(atdt_s4 >>> (DT_W + 1));
		vsum = SUM_W'(vel_s4) + SUM_W'(vh_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			npos_s5 <= sat32(psum);
			nvel_s5 <= sat32(vsum);
		end
	end

	assign new_pos = npos_s5;
	assign new_vel = nvel_s5;

endmodule
`default_nettype wire

FILE: sv/particle_attract_drag_step_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the particle attract/drag step core: config registers, valid chain.
// Depends on pads_pkg, pads_front, pads_div, pads_integ and pads_delay.

// One particle enters per clock while in_ready is high, and its result passes
// through the front end, the dividers and the integrators in that order;
// most of the depth lies in the two quotient dividers, which settle two bits per
// stage. The whole pipeline advances as one: in_ready is high whenever the
// output register is empty or its beat is being taken, so it follows out_ready
// combinationally and bubbles inside the pipeline are carried, not squeezed.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no particle is in flight.

module particle_attract_drag_step_core import pads_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [POS_W-1:0]  pos_x,
	input  wire logic signed [POS_W-1:0]  pos_y,
	input  wire logic signed [POS_W-1:0]  vel_x,
	input  wire logic signed [POS_W-1:0]  vel_y,
	input  wire logic signed [ATT_W-1:0]  attractor_x,
	input  wire logic signed [ATT_W-1:0]  attractor_y,
	input  wire logic                     attract_on,
	input  wire logic [DT_W-1:0]          time_step,
	input  wire logic                     last_in,

	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [POS_W-1:0]       new_pos_x,
	output logic signed [POS_W-1:0]       new_pos_y,
	output logic signed [POS_W-1:0]       new_vel_x,
	output logic signed [POS_W-1:0]       new_vel_y,
	output logic                          was_attracted,
	output logic                          last_out,

	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int SIDE_LAT = FRONT_LAT + DIV_LAT;
	localparam int TOT_LAT  = SIDE_LAT + INTEG_LAT;

	logic [DRAG_W-1:0] drag_q;
	logic [STR_W-1:0]  strength_q;
	logic [MIN_W-1:0]  min_dsq_q;

	logic               adv;
	logic [TOT_LAT-1:0] vld_q;

	logic [NUM_W-1:0] num_x, num_y;
	logic [DSQ_W-1:0] dsq;
	logic [QUO_W-1:0] quo_x, quo_y;
	front_flags_t     fr_flags, div_flags;
	side_t            side_in, side_out;
	out_flags_t       oflags_in, oflags_out;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q     <= DRAG_RST;
			strength_q <= STRENGTH_RST;
			min_dsq_q  <= MIN_DSQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DRAG:     drag_q     <= cfg_data[DRAG_W-1:0];
				REG_STRENGTH: strength_q <= cfg_data[STR_W-1:0];
				REG_MIN_DSQ:  min_dsq_q  <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless a finished beat is held at the output
	assign adv      = out_ready || !vld_q[TOT_LAT-1];
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOT_LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[TOT_LAT-1];

	// distance and attraction test
	pads_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.en         (adv),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.attractor_x(attractor_x),
		.attractor_y(attractor_y),
		.attract_on (attract_on),
		.strength   (strength_q),
		.min_dsq    (min_dsq_q),
		.num_x      (num_x),
		.num_y      (num_y),
		.dsq        (dsq),
		.flags      (fr_flags)
	);

	// attraction magnitudes
	pads_div #(
		.SHIFT(8 + FRAC_BITS)
	) u_div_x (
		.clk(clk),
		.en (adv),
		.num(num_x),
		.den(dsq),
		.quo(quo_x)
	);

	pads_div #(
		.SHIFT(8 + FRAC_BITS)
	) u_div_y (
		.clk(clk),
		.en (adv),
		.num(num_y),
		.den(dsq),
		.quo(quo_y)
	);

	// hold particle fields and flags in step with the divider
	always_comb begin
		side_in.pos_x     = pos_x;
		side_in.pos_y     = pos_y;
		side_in.vel_x     = vel_x;
		side_in.vel_y     = vel_y;
		side_in.time_step = time_step;
		side_in.last      = last_in;
	end

	pads_delay #(
		.WIDTH($bits(side_t)),
		.DEPTH(SIDE_LAT)
	) u_side_dly (
		.clk (clk),
		.en  (adv),
		.din (side_in),
		.dout(side_out)
	);

	pads_delay #(
		.WIDTH($bits(front_flags_t)),
		.DEPTH(DIV_LAT)
	) u_flag_dly (
		.clk (clk),
		.en  (adv),
		.din (fr_flags),
		.dout(div_flags)
	);

	// integration per axis
	pads_integ u_integ_x (
		.clk      (clk),
		.en       (adv),
		.pos      (signed'(side_out.pos_x)),
		.vel      (signed'(side_out.vel_x)),
		.dt       (side_out.time_step),
		.drag     (drag_q),
		.quo      (quo_x),
		.neg      (div_flags.neg_x),
		.attracted(div_flags.attracted),
		.new_pos  (new_pos_x),
		.new_vel  (new_vel_x)
	);

	pads_integ u_integ_y (
		.clk      (clk),
		.en       (adv),
		.pos      (signed'(side_out.pos_y)),
		.vel      (signed'(side_out.vel_y)),
		.dt       (side_out.time_step),
		.drag     (drag_q),
		.quo      (quo_y),
		.neg      (div_flags.neg_y),
		.attracted(div_flags.attracted),
		.new_pos  (new_pos_y),
		.new_vel  (new_vel_y)
	);

	// output flags in step with the integrator
	assign oflags_in.attracted = div_flags.attracted;
	assign oflags_in.last      = side_out.last;

	pads_delay #(
		.WIDTH($bits(out_flags_t)),
		.DEPTH(INTEG_LAT)
	) u_out_dly (
		.clk (clk),
		.en  (adv),
		.din (oflags_in),
		.dout(oflags_out)
	);

	assign was_attracted = oflags_out.attracted;
	assign last_out      = oflags_out.last;

`ifndef ASSERT_OFF
	// an attracted particle never reaches the divider with a zero distance
	a_no_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[FRONT_LAT-1] && fr_flags.attracted |-> dsq != '0)
		else $error("attracted particle with zero squared distance");

	// divider results stay within the attraction cap
	a_quo_capped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[SIDE_LAT-1] |-> (quo_x <= ATTR_CAP) && (quo_y <= ATTR_CAP))
		else $error("attraction magnitude above cap");

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");
`endif

endmodule
`default_nettype wire
